### rtl/core/ctsnm_pkg.sv
// Package: scene table, register indexes and pipeline constants for the scene matcher.
package ctsnm_pkg;

	localparam int ROM_LEN       = 20;
	localparam int FULL_CIRCLE   = 360;
	localparam int HALF_CIRCLE   = 180;
	localparam int GROUP_SIZE    = 4;
	localparam int SCENE_ENTRIES_DEF = 20;

	localparam int HUE_W   = 9;
	localparam int IDX_W   = 5;
	localparam int SCORE_W = 10;
	localparam int KEY_W   = SCORE_W + 1;

	typedef enum logic [1:0] {
		REG_HUE_TOL    = 2'd0,
		REG_BRIGHT_TOL = 2'd1,
		REG_SAT_THRESH = 2'd2
	} cfg_reg_t;

	typedef struct packed {
		logic [HUE_W-1:0] hue;
		logic [7:0]       bri;
		logic [7:0]       effect;
		logic [7:0]       speed;
	} scene_t;

	localparam scene_t SCENE_ROM [ROM_LEN] = '{
		'{9'd30,  8'd64,  8'd18, 8'd80},
		'{9'd0,   8'd102, 8'd19, 8'd128},
		'{9'd20,  8'd178, 8'd5,  8'd160},
		'{9'd0,   8'd204, 8'd42, 8'd180},
		'{9'd45,  8'd178, 8'd1,  8'd0},
		'{9'd60,  8'd204, 8'd56, 8'd200},
		'{9'd90,  8'd128, 8'd10, 8'd100},
		'{9'd120, 8'd102, 8'd38, 8'd140},
		'{9'd120, 8'd204, 8'd7,  8'd160},
		'{9'd150, 8'd178, 8'd84, 8'd150},
		'{9'd160, 8'd128, 8'd32, 8'd90},
		'{9'd180, 8'd153, 8'd25, 8'd120},
		'{9'd200, 8'd115, 8'd11, 8'd100},
		'{9'd220, 8'd51,  8'd21, 8'd60},
		'{9'd220, 8'd140, 8'd20, 8'd80},
		'{9'd240, 8'd89,  8'd66, 8'd70},
		'{9'd270, 8'd191, 8'd6,  8'd170},
		'{9'd300, 8'd230, 8'd64, 8'd220},
		'{9'd320, 8'd255, 8'd86, 8'd255},
		'{9'd330, 8'd153, 8'd51, 8'd130}
	};

endpackage

### rtl/core/color_to_scene_nearest_match.sv
// Top level: five-stage pipelined nearest-scene matcher.
// Takes one colour request per cycle while the output side is not stalled
// and returns one result beat per request. Stage 1 clamps and wraps the hue
// and flags white requests, stage 2 scores every table entry in parallel
// lanes, stage 3 picks a winner within groups of four lanes, stage 4 picks
// the winner across groups and stage 5 looks up the effect and speed. Each
// stage holds its beat only while the stage after it is full and stalled,
// so throughput is one beat per cycle while m_tready stays high. Tolerances
// and threshold are write-only registers with reset values 15, 18 and 150.
module color_to_scene_nearest_match
	import ctsnm_pkg::*;
#(
	parameter int SCENE_ENTRIES = SCENE_ENTRIES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // hue_deg[9:0], saturation[17:10], brightness[25:18]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // scene_index[4:0], effect_number[12:5],
	                               // effect_speed[20:13], match_score[30:21]
	output logic [1:0]  m_tuser    // matched[0], white_request[1]
);

	localparam int LANES = (SCENE_ENTRIES < ROM_LEN) ? SCENE_ENTRIES : ROM_LEN;
	localparam int NGRP  = (LANES + GROUP_SIZE - 1) / GROUP_SIZE;
	localparam int NPAD  = NGRP * GROUP_SIZE;

	logic [7:0] hue_tol_q, bri_tol_q, sat_thr_q;

	logic v1, v2, v3, v4, v5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	logic [HUE_W-1:0] hue_s1;
	logic [7:0]       bri_s1;
	logic             white_s1;

	logic [KEY_W-1:0] key_s2 [NPAD];
	logic             white_s2;

	logic [KEY_W-1:0] key_s3 [NGRP];
	logic [IDX_W-1:0] idx_s3 [NGRP];
	logic             white_s3;

	logic [KEY_W-1:0] key_s4;
	logic [IDX_W-1:0] idx_s4;
	logic             white_s4;

	logic             matched_s5, white_s5;
	logic [IDX_W-1:0] idx_s5;
	logic [7:0]       effect_s5, speed_s5;
	logic [SCORE_W-1:0] score_s5;

	logic [9:0]       in_hue;
	logic [7:0]       in_sat, in_bri;
	logic [HUE_W-1:0] hue_wrap;

	logic [KEY_W-1:0] key_c [NPAD];
	logic [KEY_W-1:0] gkey_c [NGRP];
	logic [IDX_W-1:0] gidx_c [NGRP];
	logic [KEY_W-1:0] fkey_c;
	logic [IDX_W-1:0] fidx_c;

	assign rdy5 = !v5 || m_tready;
	assign rdy4 = !v4 || rdy5;
	assign rdy3 = !v3 || rdy4;
	assign rdy2 = !v2 || rdy3;
	assign rdy1 = !v1 || rdy2;
	assign s_tready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hue_tol_q <= 8'd15;
			bri_tol_q <= 8'd18;
			sat_thr_q <= 8'd150;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_HUE_TOL:    hue_tol_q <= cfg_data;
				REG_BRIGHT_TOL: bri_tol_q <= cfg_data;
				REG_SAT_THRESH: sat_thr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v1 <= 1'b0;
			v2 <= 1'b0;
			v3 <= 1'b0;
			v4 <= 1'b0;
			v5 <= 1'b0;
		end else begin
			if (rdy1) v1 <= s_tvalid;
			if (rdy2) v2 <= v1;
			if (rdy3) v3 <= v2;
			if (rdy4) v4 <= v3;
			if (rdy5) v5 <= v4;
		end
	end

	// stage 1: clamp and wrap hue
	assign in_hue = s_tdata[9:0];
	assign in_sat = s_tdata[17:10];
	assign in_bri = s_tdata[25:18];

	always_comb begin
		if (in_hue[9]) begin
			hue_wrap = '0;
		end else if (in_hue[8:0] >= HUE_W'(FULL_CIRCLE)) begin
			hue_wrap = in_hue[8:0] - HUE_W'(FULL_CIRCLE);
		end else begin
			hue_wrap = in_hue[8:0];
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			hue_s1   <= hue_wrap;
			bri_s1   <= in_bri;
			white_s1 <= in_sat < sat_thr_q;
		end
	end

	// stage 2: score every lane
	always_comb begin
		logic [HUE_W-1:0] dh;
		logic [7:0]       db;
		for (int i = 0; i < NPAD; i++) begin
			key_c[i] = '1;
			if (i < LANES) begin
				dh = (hue_s1 > SCENE_ROM[i].hue) ? hue_s1 - SCENE_ROM[i].hue
				                                  : SCENE_ROM[i].hue - hue_s1;
				if (dh > HUE_W'(HALF_CIRCLE)) begin
					dh = HUE_W'(FULL_CIRCLE) - dh;
				end
				db = (bri_s1 > SCENE_ROM[i].bri) ? bri_s1 - SCENE_ROM[i].bri
				                                  : SCENE_ROM[i].bri - bri_s1;
				if (dh <= {1'b0, hue_tol_q} && db <= bri_tol_q) begin
					key_c[i] = {1'b0, SCORE_W'({dh, 2'b00}) + SCORE_W'(db)};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			key_s2   <= key_c;
			white_s2 <= white_s1;
		end
	end

	// stage 3: best within each group, lower lane wins ties
	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			gkey_c[g] = '1;
			gidx_c[g] = '0;
			for (int j = 0; j < GROUP_SIZE; j++) begin
				if (key_s2[g*GROUP_SIZE+j] < gkey_c[g]) begin
					gkey_c[g] = key_s2[g*GROUP_SIZE+j];
					gidx_c[g] = IDX_W'(g*GROUP_SIZE+j);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			key_s3   <= gkey_c;
			idx_s3   <= gidx_c;
			white_s3 <= white_s2;
		end
	end

	// stage 4: best across groups
	always_comb begin
		fkey_c = '1;
		fidx_c = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (key_s3[g] < fkey_c) begin
				fkey_c = key_s3[g];
				fidx_c = idx_s3[g];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			key_s4   <= fkey_c;
			idx_s4   <= fidx_c;
			white_s4 <= white_s3;
		end
	end

	// stage 5: table lookup and result register
	always_ff @(posedge clk) begin
		if (rdy5) begin
			white_s5 <= white_s4;
			if (!white_s4 && !key_s4[KEY_W-1]) begin
				matched_s5 <= 1'b1;
				idx_s5     <= idx_s4;
				effect_s5  <= SCENE_ROM[idx_s4].effect;
				speed_s5   <= SCENE_ROM[idx_s4].speed;
				score_s5   <= key_s4[SCORE_W-1:0];
			end else begin
				matched_s5 <= 1'b0;
				idx_s5     <= '0;
				effect_s5  <= '0;
				speed_s5   <= '0;
				score_s5   <= '0;
			end
		end
	end

	assign m_tvalid = v5;
	assign m_tdata  = {1'b0, score_s5, speed_s5, effect_s5, idx_s5};
	assign m_tuser  = {white_s5, matched_s5};

endmodule
